// File: sv/prf_pkg.sv
`timescale 1ns / 1ps
package prf_pkg;
  localparam int VALUE_BITS = 62;
  localparam int LIMIT_BITS = 17;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INCREMENT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT = 1'b1;
  localparam logic [VALUE_BITS-1:0] INCREMENT_RESET = VALUE_BITS'(17);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(70000);
  localparam int CNT_BITS = $clog2(2 * VALUE_BITS + 2);

  typedef enum logic [1:0] {
    MM_MUL,
    MM_REM
  } mm_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_S,
    ST_RED_I,
    ST_FX,
    ST_FY1,
    ST_FY2,
    ST_DIFF,
    ST_GCD,
    ST_DECIDE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    mm_op_t op;
  } mm_ctl_t;
endpackage

// File: sv/prf_modmul.sv
`timescale 1ns / 1ps
// Bit-serial modular unit. MM_MUL: (a*b + c) mod n with a,c < n, one bit of b per cycle.
// MM_REM: a mod n by restoring shift-in of one bit of a per cycle (c must be 0).
module prf_modmul import prf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mm_ctl_t               ctl,
  input  logic [VALUE_BITS-1:0] a,
  input  logic [VALUE_BITS-1:0] b,
  input  logic [VALUE_BITS-1:0] c,
  input  logic [VALUE_BITS-1:0] n,
  output logic                  done,
  output logic [VALUE_BITS-1:0] res
);
  logic [VALUE_BITS-1:0] r_r, r_nxt, a_r, b_r, c_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic busy_r, done_r, rem_r;
  logic [VALUE_BITS:0] dbl, sum, fin_sum;
  logic [VALUE_BITS-1:0] t;

  always_comb begin
    dbl = {r_r, rem_r ? b_r[VALUE_BITS-1] : 1'b0};
    t = (dbl >= {1'b0, n}) ? VALUE_BITS'(dbl - {1'b0, n}) : dbl[VALUE_BITS-1:0];
    sum = {1'b0, t} + {1'b0, a_r};
    r_nxt = t;
    if (!rem_r && b_r[VALUE_BITS-1])
      r_nxt = (sum >= {1'b0, n}) ? VALUE_BITS'(sum - {1'b0, n}) : sum[VALUE_BITS-1:0];
    fin_sum = {1'b0, r_r} + {1'b0, c_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rem_r <= (ctl.op == MM_REM);
        a_r <= a;
        b_r <= (ctl.op == MM_REM) ? a : b;
        c_r <= c;
        r_r <= '0;
        cnt_r <= CNT_BITS'(VALUE_BITS);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          // final add of c
          r_r <= (fin_sum >= {1'b0, n}) ? VALUE_BITS'(fin_sum - {1'b0, n})
                                        : fin_sum[VALUE_BITS-1:0];
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          r_r <= r_nxt;
          b_r <= {b_r[VALUE_BITS-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res = r_r;
endmodule

// File: sv/prf_gcd.sv
`timescale 1ns / 1ps
// Binary gcd, one subtract/shift step per cycle.
module prf_gcd import prf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] a,
  input  logic [VALUE_BITS-1:0] b,
  output logic                  done,
  output logic [VALUE_BITS-1:0] g
);
  localparam int SH_BITS = $clog2(VALUE_BITS + 1);
  logic [VALUE_BITS-1:0] u_r, v_r, g_r;
  logic [SH_BITS-1:0] k_r;
  logic busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        u_r <= a;
        v_r <= b;
        k_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (u_r == '0) begin
          g_r <= v_r << k_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (v_r == '0) begin
          g_r <= u_r << k_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r >= v_r) begin
          u_r <= u_r - v_r;
        end else begin
          v_r <= v_r - u_r;
        end
      end
    end
  end
  assign done = done_r;
  assign g = g_r;
endmodule

// File: sv/pollard_rho_factor_finder_unit.sv
`timescale 1ns / 1ps
// Pollard rho divisor finder.
// Input channel: in_valid/in_stall with in_number and in_start_value; one beat per item.
// Output channel: out_valid/out_stall with out_divisor and out_proper_found.
// Config: cfg_valid/cfg_ready, cfg_index 0 = increment, 1 = iteration_limit; write only
// while idle. cfg_ready is always high.
// One item is worked at a time; in_stall is high from acceptance until the result beat.
// Numbers of 1 or even numbers go straight to the result beat. Odd numbers first
// reduce the start value and the increment mod n, then per round run three bit-serial
// modular squarings plus a binary gcd, for up to iteration_limit rounds.
// All reductions and squarings share the one bit-serial modular multiplier.
// Reset (synchronous, rst_n low) loads increment 17 and limit 70000 and empties the block.
// A stalled result holds its payload until taken.
module pollard_rho_factor_finder_unit import prf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [VALUE_BITS-1:0]   in_number,
  input  logic [VALUE_BITS-1:0]   in_start_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VALUE_BITS-1:0]   out_divisor,
  output logic                    out_proper_found,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]   cfg_data
);
  state_t state_r, state_nxt;
  logic [VALUE_BITS-1:0] inc_r, n_r, x_r, y_r, ri_r, g_r, d_r;
  logic [LIMIT_BITS-1:0] lim_r, rounds_r;
  logic found_r;
  mm_ctl_t mm_ctl;
  logic [VALUE_BITS-1:0] mm_a, mm_b, mm_c, mm_res, gcd_res, diff;
  logic mm_done, gcd_start, gcd_done;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_divisor = d_r;
  assign out_proper_found = found_r;
  assign diff = (y_r >= x_r) ? y_r - x_r : x_r - y_r;

  prf_modmul u_mm (.clk, .rst_n, .ctl(mm_ctl), .a(mm_a), .b(mm_b), .c(mm_c), .n(n_r),
    .done(mm_done), .res(mm_res));
  prf_gcd u_gcd (.clk, .rst_n, .start(gcd_start), .a(diff), .b(n_r),
    .done(gcd_done), .g(gcd_res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inc_r <= INCREMENT_RESET;
      lim_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_index == REG_INCREMENT) inc_r <= cfg_data;
      if (cfg_valid && cfg_index == REG_LIMIT) lim_r <= cfg_data[LIMIT_BITS-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r <= in_number;
        rounds_r <= '0;
        // limit of zero: g stays 1 so the result is n
        g_r <= VALUE_BITS'(1);
        if (in_valid) begin
          if (in_number == VALUE_BITS'(1)) begin
            d_r <= VALUE_BITS'(1);
            found_r <= 1'b0;
          end else if (!in_number[0]) begin
            d_r <= VALUE_BITS'(2);
            found_r <= (in_number > VALUE_BITS'(2));
          end
        end
      end
      ST_RED_S: if (mm_done) begin
        x_r <= mm_res;
        y_r <= mm_res;
      end
      ST_RED_I: if (mm_done) ri_r <= mm_res;
      ST_FX: if (mm_done) x_r <= mm_res;
      ST_FY1: if (mm_done) y_r <= mm_res;
      ST_FY2: if (mm_done) begin
        y_r <= mm_res;
        rounds_r <= rounds_r + 1'b1;
      end
      ST_GCD: if (gcd_done) g_r <= gcd_res;
      ST_DECIDE: if (g_r == VALUE_BITS'(1) || g_r == n_r) begin
        d_r <= n_r;
        found_r <= 1'b0;
      end else begin
        d_r <= g_r;
        found_r <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mm_ctl = '{start: 1'b0, op: MM_MUL};
    mm_a = x_r;
    mm_b = x_r;
    mm_c = ri_r;
    gcd_start = 1'b0;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        if (in_number == VALUE_BITS'(1) || !in_number[0]) state_nxt = ST_OUT;
        else begin
          state_nxt = ST_RED_S;
          mm_ctl = '{start: 1'b1, op: MM_REM};
          mm_a = in_start_value;
          mm_c = '0;
        end
      end
      ST_RED_S: begin
        mm_c = '0;
        if (mm_done) begin
          state_nxt = ST_RED_I;
          mm_ctl = '{start: 1'b1, op: MM_REM};
          mm_a = inc_r;
        end
      end
      ST_RED_I: if (mm_done) begin
        if (lim_r == '0) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_FX;
          mm_ctl = '{start: 1'b1, op: MM_MUL};
          mm_c = mm_res;
        end
      end
      ST_FX: if (mm_done) begin
        state_nxt = ST_FY1;
        mm_ctl = '{start: 1'b1, op: MM_MUL};
        mm_a = y_r;
        mm_b = y_r;
      end
      ST_FY1: if (mm_done) begin
        state_nxt = ST_FY2;
        mm_ctl = '{start: 1'b1, op: MM_MUL};
        mm_a = mm_res;
        mm_b = mm_res;
      end
      ST_FY2: if (mm_done) state_nxt = ST_DIFF;
      ST_DIFF: begin
        gcd_start = 1'b1;
        state_nxt = ST_GCD;
      end
      ST_GCD: if (gcd_done) begin
        if (gcd_res == VALUE_BITS'(1) && rounds_r < lim_r) begin
          state_nxt = ST_FX;
          mm_ctl = '{start: 1'b1, op: MM_MUL};
        end else state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = ST_OUT;
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: sv/prf_checker.sv
`timescale 1ns / 1ps
module prf_checker import prf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [VALUE_BITS-1:0] out_divisor,
  input logic                  out_proper_found
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_divisor)) else $error("out held");
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_proper_gt1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_proper_found |-> out_divisor > VALUE_BITS'(1)) else $error("bad divisor");
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("no work started");
endmodule

bind pollard_rho_factor_finder_unit prf_checker u_prf_checker (.clk, .rst_n, .in_valid,
  .in_stall, .out_valid, .out_stall, .out_divisor, .out_proper_found);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import prf_pkg::*;

  localparam int STALL_LIMIT = 1000000;
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [VALUE_BITS-1:0]   in_number = '0;
  logic [VALUE_BITS-1:0]   in_start_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [VALUE_BITS-1:0]   out_divisor;
  logic                    out_proper_found;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_INCREMENT;
  logic [VALUE_BITS-1:0]   cfg_data = '0;

  pollard_rho_factor_finder_unit DUT (.*);

  typedef struct {
    logic [VALUE_BITS-1:0] number;
    logic [VALUE_BITS-1:0] start;
  } job_t;

  job_t                  pending_q[$];
  logic [VALUE_BITS-1:0] divisor_q[$];
  logic                  found_q[$];

  logic [VALUE_BITS-1:0] cur_increment = INCREMENT_RESET;
  logic [LIMIT_BITS-1:0] cur_limit = LIMIT_RESET;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_len = 0;
  int  hold_cnt = 0;
  bit  in_took = 1'b0;
  int  quiet_cycles = 0;
  int  errors = 0;

  initial forever #2 clk = ~clk;

  // (a + b) mod n with a, b < n
  function automatic longint unsigned addm(longint unsigned a, longint unsigned b,
                                           longint unsigned n);
    longint unsigned room;
    room = n - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  function automatic longint unsigned rho_step(longint unsigned v, longint unsigned c,
                                               longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = addm(r, r, n);
      if (v[i]) r = addm(r, v, n);
    end
    return addm(r, c, n);
  endfunction

  task automatic predict_divisor(input longint unsigned n, input longint unsigned s,
                                 output logic [VALUE_BITS-1:0] d, output logic f);
    longint unsigned c, x, y, g, a, b, t, rounds;
    if (n == 1) begin
      d = 1; f = 1'b0;
    end else if (n[0] == 1'b0) begin
      d = 2; f = (n > 2);
    end else begin
      c = longint'(cur_increment) % n;
      x = s % n;
      y = x;
      g = 1;
      rounds = 0;
      while (g == 1 && rounds < cur_limit) begin
        rounds++;
        x = rho_step(x, c, n);
        y = rho_step(y, c, n);
        y = rho_step(y, c, n);
        a = (y >= x) ? y - x : x - y;
        b = n;
        while (a != 0) begin
          t = b % a; b = a; a = t;
        end
        g = b;
      end
      if (g == 1 || g == n) begin
        d = VALUE_BITS'(n); f = 1'b0;
      end else begin
        d = VALUE_BITS'(g); f = 1'b1;
      end
    end
  endtask

  // acceptance, prediction, result check, watchdog
  always @(posedge clk) begin
    logic [VALUE_BITS-1:0] d;
    logic f;
    in_took <= in_valid && !in_stall;
    if (rst_n && (in_valid && !in_stall || out_valid && !out_stall || cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[pollard_rho_factor_finder_unit] ERROR");
      $finish;
    end else begin
      if (rst_n && in_valid && !in_stall) begin
        predict_divisor(64'(in_number), 64'(in_start_value), d, f);
        divisor_q = {divisor_q, d};
        found_q = {found_q, f};
      end
      if (rst_n && out_valid && !out_stall) begin
        if (divisor_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          d = divisor_q.pop_front();
          f = found_q.pop_front();
          if (out_divisor !== d) begin
            $error("divisor: expected %0d, got %0d", d, out_divisor);
            errors++;
          end
          if (out_proper_found !== f) begin
            $error("proper_found: expected %0b, got %0b", f, out_proper_found);
            errors++;
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    job_t j;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        j = pending_q.pop_front();
        in_valid <= 1'b1;
        in_number <= j.number;
        in_start_value <= j.start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic add_job(input logic [VALUE_BITS-1:0] n, input logic [VALUE_BITS-1:0] s);
    job_t j;
    j.number = n;
    j.start = s;
    pending_q = {pending_q, j};
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && divisor_q.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [VALUE_BITS-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_INCREMENT) cur_increment = v;
    else cur_limit = v[LIMIT_BITS-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_wide();
    return VALUE_BITS'({$urandom(), $urandom()});
  endfunction

  // mostly numbers with small factors, so rho ends within a few rounds
  task automatic add_random_job(input int small_only);
    logic [VALUE_BITS-1:0] n;
    int k;
    k = $urandom_range(99);
    if (small_only) n = VALUE_BITS'(2 * $urandom_range(1, 300) + 1);
    else if (k < 10) n = (k < 3) ? 1 : rand_wide() & ~VALUE_BITS'(1);
    else if (k < 50)
      n = VALUE_BITS'((2 * $urandom_range(1, 127) + 1) * (2 * $urandom_range(1, 127) + 1));
    else if (k < 80) n = rand_wide() | 1;
    else n = VALUE_BITS'(2 * $urandom_range(1, 255) + 1);
    add_job(n, ($urandom_range(3) == 0) ? rand_wide() : VALUE_BITS'($urandom_range(2, 1000)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings
    add_job(1, 5);
    add_job(0, 3);
    add_job(2, 0);
    add_job(4, 2);
    add_job(VMAX - 1, VMAX);
    add_job(9, 2);
    add_job(15, VMAX);
    add_job(7, 2);
    add_job(3, 0);
    add_job(21, 20);
    add_job(VMAX, 2);
    drain();

    // widest increment, single round
    write_reg(REG_INCREMENT, VMAX);
    write_reg(REG_LIMIT, 1);
    add_job(15, 2);
    add_job(35, 3);
    add_job(VMAX, VMAX);
    add_job(8633, 5);
    drain();

    // no rounds at all
    write_reg(REG_LIMIT, 0);
    write_reg(REG_INCREMENT, 0);
    add_job(15, 2);
    add_job(25, 7);
    add_job(6, 1);
    drain();

    // widest limit: small odd numbers only, cycle closes within n rounds
    write_reg(REG_LIMIT, VALUE_BITS'({LIMIT_BITS{1'b1}}));
    write_reg(REG_INCREMENT, 1);
    add_job(97, 2);
    add_job(91, 3);
    for (int i = 0; i < 4; i++) add_random_job(1);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_INCREMENT, rand_wide());
      write_reg(REG_LIMIT, VALUE_BITS'($urandom_range(1, 32)));
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      // long receiver hold while items keep coming
      if (p == 0) hold_len = 30000;
      for (int i = 0; i < 25; i++) add_random_job(0);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("[pollard_rho_factor_finder_unit] OK");
    else $display("[pollard_rho_factor_finder_unit] ERROR");
    $finish;
  end
endmodule
